FILE: design/assert_macros.svh
// Assertion macros for the checker file of this block.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion with a caller-supplied message.
`define AM_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion with a generic message.
`define AM_ASSERT(lbl, prop) \
  `AM_ASSERT_MSG(lbl, prop, "playback cache assertion failed")

`endif

FILE: design/pfc_pkg.sv
package pfc_pkg;

  localparam int MAX_FRAMES = 1024;
  localparam int FRAMES_LIM = (MAX_FRAMES < 1024) ? MAX_FRAMES : 1024;

  localparam int FRAME_W    = 10;
  localparam int CNT_W      = 11;
  localparam int FILL_W     = 7;
  localparam int PCT        = 100;
  localparam int DIVIDEND_W = CNT_W + FILL_W;

  // The cache map is kept as rows of 32 frame bits.
  localparam int ROW_W  = 32;
  localparam int BIT_AW = $clog2(ROW_W);
  localparam int ROW_AW = FRAME_W - BIT_AW;
  localparam int ROWS   = 2 ** ROW_AW;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [2:0] OP_ARRIVE    = 3'd0;
  localparam logic [2:0] OP_STEP_FWD  = 3'd1;
  localparam logic [2:0] OP_STEP_BACK = 3'd2;
  localparam logic [2:0] OP_SEEK      = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd2;
  localparam logic [1:0] REG_SKIP_FRAMES = 2'd3;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd400;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 11'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOOKUP,
    ST_TGT,
    ST_SCAN_START,
    ST_SCAN_ISSUE,
    ST_SCAN_CHK,
    ST_RELOAD,
    ST_INS,
    ST_FILL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [ROW_W-1:0]  data;
  } map_wr_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CNT_W-1:0]      divisor;
  } div_req_t;

endpackage

FILE: design/playback_frame_cache_policy.sv
// Frame cache bookkeeping for sequence playback. Each input word carries an
// operation (frame arrived, step forward, step back, seek, clear) and a frame
// index; each one produces exactly one result word with the position after
// the operation, hit / inserted / eviction flags, the evicted frame and the
// fill level in percent of the capacity in use (the lesser of max_entries and
// frame_count, with frame_count capped at 1024). Words are processed one at
// a time: in_stall is high from the cycle after a word is accepted until its
// result has been moved into the output register, and a finished result may
// wait there while the next word is taken. A serial divider forms the fill
// percentage. When the store is full an eviction walks the cache map row by
// row, 32 frames per row, each row with one synchronous read and one check,
// across both sides of the position if needed. The map sits in a 32 x 32
// memory with one write and one read port and one valid flag per row, so
// reset and the clear operation empty it at once with no clearing pass.
// Registers are written through the APB port at byte addresses 0, 4, 8 and
// 12 (max_entries, frame_count, loop_enable, skip_frames) and should only be
// written while no word is in flight.
module playback_frame_cache_policy (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_op,
  input  logic [pfc_pkg::FRAME_W-1:0]   in_frame_index,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfc_pkg::FRAME_W-1:0]   out_shown_frame,
  output logic                          out_hit,
  output logic                          out_inserted,
  output logic                          out_evict_valid,
  output logic [pfc_pkg::FRAME_W-1:0]   out_evicted_frame,
  output logic [pfc_pkg::FILL_W-1:0]    out_fill_percent,
  output logic                          out_halted,
  output logic                          out_bad_index,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pfc_pkg::CFG_AW-1:0]    paddr,
  input  logic [pfc_pkg::CFG_DW-1:0]    pwdata,
  output logic [pfc_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  // Configuration registers.
  logic [pfc_pkg::CNT_W-1:0] max_entries_r;
  logic [pfc_pkg::CNT_W-1:0] frame_count_r;
  logic                      loop_enable_r;
  logic                      skip_frames_r;
  logic [1:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[pfc_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= pfc_pkg::MAX_ENTRIES_RST;
      frame_count_r <= pfc_pkg::FRAME_COUNT_RST;
      loop_enable_r <= 1'b0;
      skip_frames_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        pfc_pkg::REG_MAX_ENTRIES: max_entries_r <= pwdata[pfc_pkg::CNT_W-1:0];
        pfc_pkg::REG_FRAME_COUNT: frame_count_r <= pwdata[pfc_pkg::CNT_W-1:0];
        pfc_pkg::REG_LOOP_ENABLE: loop_enable_r <= pwdata[0];
        pfc_pkg::REG_SKIP_FRAMES: skip_frames_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      pfc_pkg::REG_MAX_ENTRIES: prdata = pfc_pkg::CFG_DW'(max_entries_r);
      pfc_pkg::REG_FRAME_COUNT: prdata = pfc_pkg::CFG_DW'(frame_count_r);
      pfc_pkg::REG_LOOP_ENABLE: prdata = pfc_pkg::CFG_DW'(loop_enable_r);
      pfc_pkg::REG_SKIP_FRAMES: prdata = pfc_pkg::CFG_DW'(skip_frames_r);
      default:                  prdata = '0;
    endcase
  end

  // Control and architectural state.
  pfc_pkg::state_t state_r, state_nxt;

  logic [2:0]                    op_r, op_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   idx_r, idx_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   tgt_r, tgt_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   pos_r, pos_nxt;
  logic                          dir_r, dir_nxt;
  logic [pfc_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          hit_r, hit_nxt;
  logic                          ins_r, ins_nxt;
  logic                          evv_r, evv_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   evf_r, evf_nxt;
  logic                          halt_r, halt_nxt;
  logic                          bad_r, bad_nxt;
  logic [pfc_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic                          high_side_r, high_side_nxt;
  logic                          second_r, second_nxt;
  logic [pfc_pkg::ROW_AW-1:0]    row_r, row_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   o_shown_r, o_shown_nxt;
  logic                          o_hit_r, o_hit_nxt;
  logic                          o_ins_r, o_ins_nxt;
  logic                          o_evv_r, o_evv_nxt;
  logic [pfc_pkg::FRAME_W-1:0]   o_evf_r, o_evf_nxt;
  logic [pfc_pkg::FILL_W-1:0]    o_fill_r, o_fill_nxt;
  logic                          o_halt_r, o_halt_nxt;
  logic                          o_bad_r, o_bad_nxt;

  // Map memory and divider hookup.
  pfc_pkg::map_wr_t              map_wr;
  logic                          map_clr;
  logic [pfc_pkg::ROW_AW-1:0]    rd_addr;
  logic [pfc_pkg::ROW_W-1:0]     rd_data;
  pfc_pkg::div_req_t             div_req;
  logic [pfc_pkg::DIVIDEND_W-1:0] div_quo;
  logic                          div_done;

  pfc_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (map_clr),
    .wr      (map_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Effective frame count and capacity, and the bounds of the two
  // eviction sides around the current position.
  logic [pfc_pkg::CNT_W-1:0] n_eff, cap, pos_ext, lim, lim_m1, n_m1, pos_p1;
  logic                      low_empty, high_empty;
  logic [pfc_pkg::ROW_AW-1:0] low_last_row, high_first_row, high_last_row;

  always_comb begin
    n_eff = (frame_count_r > pfc_pkg::CNT_W'(pfc_pkg::FRAMES_LIM)) ?
            pfc_pkg::CNT_W'(pfc_pkg::FRAMES_LIM) : frame_count_r;
    cap        = (max_entries_r < n_eff) ? max_entries_r : n_eff;
    pos_ext    = {1'b0, pos_r};
    lim        = (pos_ext < n_eff) ? pos_ext : n_eff;
    lim_m1     = lim - 1'b1;
    n_m1       = n_eff - 1'b1;
    pos_p1     = pos_ext + 1'b1;
    low_empty  = (lim == '0);
    high_empty = (pos_p1 >= n_eff);
    low_last_row   = lim_m1[pfc_pkg::FRAME_W-1:pfc_pkg::BIT_AW];
    high_first_row = n_m1[pfc_pkg::FRAME_W-1:pfc_pkg::BIT_AW];
    high_last_row  = pos_p1[pfc_pkg::FRAME_W-1:pfc_pkg::BIT_AW];
  end

  // Candidate search within the row that has just been read. The low side
  // wants the lowest cached frame below the position, the high side the
  // highest cached frame above it.
  logic [pfc_pkg::ROW_W-1:0]  cand_mask, cand;
  logic                       found;
  logic [pfc_pkg::BIT_AW-1:0] sel;
  logic [pfc_pkg::CNT_W-1:0]  fidx;

  always_comb begin
    fidx = '0;
    for (int j = 0; j < pfc_pkg::ROW_W; j++) begin
      fidx = {1'b0, row_r, pfc_pkg::BIT_AW'(j)};
      cand_mask[j] = high_side_r ? ((fidx > pos_ext) && (fidx < n_eff)) : (fidx < lim);
    end
    cand  = rd_data & cand_mask;
    found = |cand;
    sel   = '0;
    if (high_side_r) begin
      for (int j = 0; j < pfc_pkg::ROW_W; j++) begin
        if (cand[j]) sel = pfc_pkg::BIT_AW'(j);
      end
    end else begin
      for (int j = pfc_pkg::ROW_W - 1; j >= 0; j--) begin
        if (cand[j]) sel = pfc_pkg::BIT_AW'(j);
      end
    end
  end

  logic [pfc_pkg::ROW_W-1:0]  tgt_onehot;
  logic [pfc_pkg::ROW_AW-1:0] tgt_row;
  logic                       tgt_bit;

  assign tgt_row    = tgt_r[pfc_pkg::FRAME_W-1:pfc_pkg::BIT_AW];
  assign tgt_onehot = pfc_pkg::ROW_W'(1) << tgt_r[pfc_pkg::BIT_AW-1:0];
  assign tgt_bit    = |(rd_data & tgt_onehot);

  // Sequencer: next state, datapath updates and memory / divider requests.
  always_comb begin
    logic [pfc_pkg::FRAME_W-1:0] t;
    logic                        side_empty;
    logic [pfc_pkg::ROW_AW-1:0]  end_row;

    t          = '0;
    side_empty = high_side_r ? high_empty : low_empty;
    end_row    = high_side_r ? high_last_row : low_last_row;

    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    tgt_nxt       = tgt_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    cnt_nxt       = cnt_r;
    hit_nxt       = hit_r;
    ins_nxt       = ins_r;
    evv_nxt       = evv_r;
    evf_nxt       = evf_r;
    halt_nxt      = halt_r;
    bad_nxt       = bad_r;
    fill_nxt      = fill_r;
    high_side_nxt = high_side_r;
    second_nxt    = second_r;
    row_nxt       = row_r;

    out_valid_nxt = out_valid_r && out_stall;
    o_shown_nxt   = o_shown_r;
    o_hit_nxt     = o_hit_r;
    o_ins_nxt     = o_ins_r;
    o_evv_nxt     = o_evv_r;
    o_evf_nxt     = o_evf_r;
    o_fill_nxt    = o_fill_r;
    o_halt_nxt    = o_halt_r;
    o_bad_nxt     = o_bad_r;

    map_clr          = 1'b0;
    map_wr.en        = 1'b0;
    map_wr.addr      = tgt_row;
    map_wr.data      = rd_data | tgt_onehot;
    rd_addr          = tgt_row;
    div_req.start    = 1'b0;
    div_req.dividend = pfc_pkg::DIVIDEND_W'(cnt_r) * pfc_pkg::DIVIDEND_W'(pfc_pkg::PCT);
    div_req.divisor  = cap;

    case (state_r)
      pfc_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          idx_nxt   = in_frame_index;
          hit_nxt   = 1'b0;
          ins_nxt   = 1'b0;
          evv_nxt   = 1'b0;
          evf_nxt   = '0;
          halt_nxt  = 1'b0;
          bad_nxt   = 1'b0;
          state_nxt = pfc_pkg::ST_DECODE;
        end
      end

      pfc_pkg::ST_DECODE: begin
        state_nxt = pfc_pkg::ST_FILL;
        case (op_r)
          pfc_pkg::OP_ARRIVE: begin
            if ({1'b0, idx_r} >= n_eff) begin
              bad_nxt = 1'b1;
            end else begin
              tgt_nxt   = idx_r;
              state_nxt = pfc_pkg::ST_LOOKUP;
            end
          end
          pfc_pkg::OP_STEP_FWD: begin
            dir_nxt = 1'b1;
            if (n_eff != '0) begin
              if (pos_ext >= n_m1) begin
                if (loop_enable_r) begin
                  t = '0;
                end else begin
                  t        = n_m1[pfc_pkg::FRAME_W-1:0];
                  halt_nxt = 1'b1;
                end
              end else begin
                t = pos_r + 1'b1;
              end
              pos_nxt   = t;
              tgt_nxt   = t;
              state_nxt = pfc_pkg::ST_LOOKUP;
            end
          end
          pfc_pkg::OP_STEP_BACK: begin
            dir_nxt = 1'b0;
            t       = pos_r - 1'b1;
            if (n_eff != '0) begin
              if (pos_r == '0) begin
                halt_nxt = 1'b1;
              end else if ({1'b0, t} < n_eff) begin
                // A target still beyond a lowered frame count is dropped.
                pos_nxt   = t;
                tgt_nxt   = t;
                state_nxt = pfc_pkg::ST_LOOKUP;
              end
            end
          end
          pfc_pkg::OP_SEEK: begin
            if ({1'b0, idx_r} >= n_eff) begin
              bad_nxt = 1'b1;
            end else begin
              pos_nxt   = idx_r;
              tgt_nxt   = idx_r;
              state_nxt = pfc_pkg::ST_LOOKUP;
            end
          end
          pfc_pkg::OP_CLEAR: begin
            map_clr = 1'b1;
            cnt_nxt = '0;
            pos_nxt = '0;
            dir_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      pfc_pkg::ST_LOOKUP: begin
        state_nxt = pfc_pkg::ST_TGT;
      end

      pfc_pkg::ST_TGT: begin
        // rd_data holds the target's row; it stays there for ST_INS.
        if (tgt_bit) begin
          hit_nxt   = (op_r != pfc_pkg::OP_ARRIVE);
          state_nxt = pfc_pkg::ST_FILL;
        end else if ((op_r != pfc_pkg::OP_ARRIVE) && skip_frames_r) begin
          state_nxt = pfc_pkg::ST_FILL;
        end else if (cnt_r >= cap) begin
          high_side_nxt = !dir_r;
          second_nxt    = 1'b0;
          state_nxt     = pfc_pkg::ST_SCAN_START;
        end else begin
          state_nxt = pfc_pkg::ST_INS;
        end
      end

      pfc_pkg::ST_SCAN_START: begin
        if (side_empty) begin
          if (second_r) begin
            state_nxt = pfc_pkg::ST_RELOAD;
          end else begin
            high_side_nxt = !high_side_r;
            second_nxt    = 1'b1;
          end
        end else begin
          row_nxt   = high_side_r ? high_first_row : '0;
          state_nxt = pfc_pkg::ST_SCAN_ISSUE;
        end
      end

      pfc_pkg::ST_SCAN_ISSUE: begin
        rd_addr   = row_r;
        state_nxt = pfc_pkg::ST_SCAN_CHK;
      end

      pfc_pkg::ST_SCAN_CHK: begin
        if (found) begin
          map_wr.en   = 1'b1;
          map_wr.addr = row_r;
          map_wr.data = rd_data & ~(pfc_pkg::ROW_W'(1) << sel);
          if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
          evv_nxt     = 1'b1;
          evf_nxt     = {row_r, sel};
          state_nxt   = pfc_pkg::ST_RELOAD;
        end else if (row_r == end_row) begin
          if (second_r) begin
            state_nxt = pfc_pkg::ST_RELOAD;
          end else begin
            high_side_nxt = !high_side_r;
            second_nxt    = 1'b1;
            state_nxt     = pfc_pkg::ST_SCAN_START;
          end
        end else begin
          row_nxt   = high_side_r ? (row_r - 1'b1) : (row_r + 1'b1);
          state_nxt = pfc_pkg::ST_SCAN_ISSUE;
        end
      end

      pfc_pkg::ST_RELOAD: begin
        // Re-read the target row, which the eviction may have just written.
        state_nxt = pfc_pkg::ST_INS;
      end

      pfc_pkg::ST_INS: begin
        if (cnt_r < cap) begin
          map_wr.en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ins_nxt   = 1'b1;
        end
        state_nxt = pfc_pkg::ST_FILL;
      end

      pfc_pkg::ST_FILL: begin
        if (cap == '0) begin
          fill_nxt  = (cnt_r != '0) ? pfc_pkg::FILL_W'(pfc_pkg::PCT) : '0;
          state_nxt = pfc_pkg::ST_DONE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = pfc_pkg::ST_DIV;
        end
      end

      pfc_pkg::ST_DIV: begin
        if (div_done) begin
          fill_nxt  = (div_quo > pfc_pkg::DIVIDEND_W'(pfc_pkg::PCT)) ?
                      pfc_pkg::FILL_W'(pfc_pkg::PCT) : div_quo[pfc_pkg::FILL_W-1:0];
          state_nxt = pfc_pkg::ST_DONE;
        end
      end

      pfc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_shown_nxt   = pos_r;
          o_hit_nxt     = hit_r;
          o_ins_nxt     = ins_r;
          o_evv_nxt     = evv_r;
          o_evf_nxt     = evf_r;
          o_fill_nxt    = fill_r;
          o_halt_nxt    = halt_r;
          o_bad_nxt     = bad_r;
          state_nxt     = pfc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      dir_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      dir_r       <= dir_nxt;
    end
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    tgt_r       <= tgt_nxt;
    hit_r       <= hit_nxt;
    ins_r       <= ins_nxt;
    evv_r       <= evv_nxt;
    evf_r       <= evf_nxt;
    halt_r      <= halt_nxt;
    bad_r       <= bad_nxt;
    fill_r      <= fill_nxt;
    high_side_r <= high_side_nxt;
    second_r    <= second_nxt;
    row_r       <= row_nxt;
    o_shown_r   <= o_shown_nxt;
    o_hit_r     <= o_hit_nxt;
    o_ins_r     <= o_ins_nxt;
    o_evv_r     <= o_evv_nxt;
    o_evf_r     <= o_evf_nxt;
    o_fill_r    <= o_fill_nxt;
    o_halt_r    <= o_halt_nxt;
    o_bad_r     <= o_bad_nxt;
  end

  assign in_stall          = (state_r != pfc_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_shown_frame   = o_shown_r;
  assign out_hit           = o_hit_r;
  assign out_inserted      = o_ins_r;
  assign out_evict_valid   = o_evv_r;
  assign out_evicted_frame = o_evf_r;
  assign out_fill_percent  = o_fill_r;
  assign out_halted        = o_halt_r;
  assign out_bad_index     = o_bad_r;

endmodule

FILE: design/pfc_map.sv
module pfc_map (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr,
  input  pfc_pkg::map_wr_t             wr,
  input  logic [pfc_pkg::ROW_AW-1:0]   rd_addr,
  output logic [pfc_pkg::ROW_W-1:0]    rd_data
);

  logic [pfc_pkg::ROW_W-1:0] mem [pfc_pkg::ROWS];
  logic [pfc_pkg::ROWS-1:0]  vld_r;
  logic [pfc_pkg::ROW_W-1:0] rdat_r;
  logic                      rvld_r;

  // A row that has not been written since reset or clear reads as empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdat_r <= mem[rd_addr];
    rvld_r <= vld_r[rd_addr];
  end

  assign rd_data = rvld_r ? rdat_r : '0;

endmodule

FILE: design/pfc_div.sv
module pfc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfc_pkg::div_req_t                req,
  output logic [pfc_pkg::DIVIDEND_W-1:0]   quotient,
  output logic                             done
);

  localparam int STEP_W = $clog2(pfc_pkg::DIVIDEND_W);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [STEP_W-1:0]               step_r, step_nxt;
  logic [pfc_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [pfc_pkg::DIVIDEND_W-1:0]  quo_r, quo_nxt;
  logic [pfc_pkg::CNT_W-1:0]       dvs_r, dvs_nxt;
  logic [pfc_pkg::CNT_W:0]         trial;
  logic [pfc_pkg::CNT_W:0]         diff;
  logic                            ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[pfc_pkg::DIVIDEND_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[pfc_pkg::CNT_W-1:0] : trial[pfc_pkg::CNT_W-1:0];
      quo_nxt = {quo_r[pfc_pkg::DIVIDEND_W-2:0], ge};
      if (step_r == STEP_W'(pfc_pkg::DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: design/pfc_checker.sv
`include "assert_macros.svh"

module pfc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pfc_pkg::FRAME_W-1:0]  out_shown_frame,
  input logic                         out_hit,
  input logic                         out_inserted,
  input logic                         out_evict_valid,
  input logic [pfc_pkg::FRAME_W-1:0]  out_evicted_frame,
  input logic [pfc_pkg::FILL_W-1:0]   out_fill_percent,
  input logic                         out_halted,
  input logic                         out_bad_index
);

  // Words are processed one at a time, so an accepted word blocks the next.
  `AM_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall)

  `AM_ASSERT(a_result_held, out_valid && out_stall |=> out_valid && $stable(out_shown_frame) && $stable(out_evicted_frame) && $stable(out_fill_percent))

  `AM_ASSERT(a_evicted_zero, out_valid && !out_evict_valid |-> out_evicted_frame == '0)

  `AM_ASSERT(a_fill_range, out_valid |-> out_fill_percent <= pfc_pkg::FILL_W'(pfc_pkg::PCT))

  // A rejected frame index leaves the cache and the position untouched.
  `AM_ASSERT(a_bad_quiet, out_valid && out_bad_index |-> !out_hit && !out_inserted && !out_evict_valid && !out_halted)

endmodule

bind playback_frame_cache_policy pfc_checker u_pfc_checker (.*);
